@@ design/ssuv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssuv_pkg: shared types and constants of the seek step unit vector block
// Widths, facing codes, register addresses and the per-stage control record.
// ----------------------------------------------------------------------------
package ssuv_pkg;

    localparam int COORD_FRACTION_BITS = 4;
    localparam int UNIT_FRACTION_BITS  = 14;
    localparam int SHIFT_BITS          = UNIT_FRACTION_BITS - COORD_FRACTION_BITS;

    localparam int DW   = 17;            // difference magnitude width
    localparam int SQW  = 2 * DW;        // width of each square
    localparam int RTW  = DW + 1;        // rounded root width
    localparam int NUMW = DW + UNIT_FRACTION_BITS + 1; // dividend width
    localparam int QW   = NUMW;          // quotient width
    localparam int SPW  = 8;
    localparam int PW   = QW + SPW + COORD_FRACTION_BITS;

    localparam logic [SPW-1:0] SPEED_RESET = 8'd1;

    typedef enum logic [1:0] {
        FACE_RIGHT = 2'd0,
        FACE_LEFT  = 2'd1,
        FACE_DOWN  = 2'd2
    } t_facing;

    localparam logic [0:0] ADDR_STEP_SPEED = 1'b0;

    // Side information that rides alongside the arithmetic.
    typedef struct packed {
        logic            zero;
        logic            neg_x;
        logic            neg_y;
        t_facing         face;
        logic [15:0]     mover_x;
        logic [15:0]     mover_y;
        logic [SPW-1:0]  speed;
    } t_side;

endpackage

@@ design/seek_step_unit_vector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seek_step_unit_vector_unit: moves a mover one step toward a target
// Difference, rounded root, rounded unit vector, speed scaling, saturation.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; o_busy stays low. The root and divide
// are unrolled into one register stage per result bit.
// Reset: synchronous active low, clears valid bits and sets step_speed to 1.
// Results are shown for one cycle; the receiver cannot stall.
module seek_step_unit_vector_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic signed [15:0]    i_target_x,
    input  logic signed [15:0]    i_target_y,
    input  logic signed [15:0]    i_mover_x,
    input  logic signed [15:0]    i_mover_y,
    output logic                  o_valid,
    output logic signed [15:0]    o_new_x,
    output logic signed [15:0]    o_new_y,
    output logic [1:0]            o_facing,
    output logic                  o_saturated,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ssuv_pkg::*;

    localparam int RS  = RTW;   // root stages
    localparam int DS  = QW;    // divide stages
    localparam int RBW = SQW + 2;

    logic [SPW-1:0] r_speed;
    assign pready = 1'b1;
    assign o_busy = 1'b0;
    assign prdata = (paddr[1:0] == {ADDR_STEP_SPEED, 1'b0}) ? {24'd0, r_speed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
        end else if (psel && penable && pwrite
                     && paddr[1:0] == {ADDR_STEP_SPEED, 1'b0}) begin
            r_speed <= pwdata[SPW-1:0];
        end
    end

    // Stage 1: differences, magnitudes, facing.
    logic          r_v1;
    t_side         r_s1;
    logic [DW-1:0] r_ax, r_ay;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [DW-1:0] w_ax, w_ay;
    t_facing       w_face;

    always_comb begin
        w_dx = DW'(i_target_x) - DW'(i_mover_x);
        w_dy = DW'(i_target_y) - DW'(i_mover_y);
        w_ax = w_dx[DW-1] ? DW'(-w_dx) : w_dx;
        w_ay = w_dy[DW-1] ? DW'(-w_dy) : w_dy;
        if (w_ax > w_ay) begin
            w_face = (!w_dx[DW-1] && w_dx != 0) ? FACE_RIGHT : FACE_LEFT;
        end else if (!w_dy[DW-1] && w_dy != 0) begin
            w_face = FACE_DOWN;
        end else begin
            w_face = (!w_dx[DW-1] && w_dx != 0) ? FACE_RIGHT : FACE_LEFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= i_start;
        r_ax <= w_ax;
        r_ay <= w_ay;
        r_s1.zero    <= (w_ax == 0) && (w_ay == 0);
        r_s1.neg_x   <= w_dx[DW-1];
        r_s1.neg_y   <= w_dy[DW-1];
        r_s1.face    <= w_face;
        r_s1.mover_x <= i_mover_x;
        r_s1.mover_y <= i_mover_y;
        r_s1.speed   <= r_speed;
    end

    // Stage 2: squares.
    logic          r_v2;
    t_side         r_s2;
    logic [DW-1:0] r_ax2, r_ay2;
    logic [SQW-1:0] r_sqx, r_sqy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_s2  <= r_s1;
        r_ax2 <= r_ax;
        r_ay2 <= r_ay;
        r_sqx <= SQW'(r_ax * r_ax);
        r_sqy <= SQW'(r_ay * r_ay);
    end

    // Root pipeline: one result bit per stage (restoring method).
    logic          rv   [RS+1];
    t_side         rs   [RS+1];
    logic [DW-1:0] rax  [RS+1];
    logic [DW-1:0] ray  [RS+1];
    logic [RBW-1:0] rrem [RS+1];
    logic [RTW-1:0] rroot[RS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rv[0] <= 1'b0;
        else          rv[0] <= r_v2;
        rs[0]    <= r_s2;
        rax[0]   <= r_ax2;
        ray[0]   <= r_ay2;
        rrem[0]  <= RBW'(r_sqx) + RBW'(r_sqy);
        rroot[0] <= '0;
    end

    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam int B = RS - 1 - k;
        logic [RBW-1:0] w_trial;
        logic           w_ok;
        assign w_trial = (RBW'(rroot[k]) << (B + 1)) + (RBW'(1) << (2 * B));
        assign w_ok    = rrem[k] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rv[k+1] <= 1'b0;
            else          rv[k+1] <= rv[k];
            rs[k+1]    <= rs[k];
            rax[k+1]   <= rax[k];
            ray[k+1]   <= ray[k];
            rrem[k+1]  <= w_ok ? rrem[k] - w_trial : rrem[k];
            rroot[k+1] <= w_ok ? (rroot[k] | (RTW'(1) << B)) : rroot[k];
        end
    end

    // Round the root, form dividends.
    logic            r_v3;
    t_side           r_s3;
    logic [RTW-1:0]  r_len;
    logic [NUMW-1:0] r_nx, r_ny;
    logic [RTW-1:0]  w_len;
    assign w_len = (RTW'(rrem[RS]) > rroot[RS] || rrem[RS] > RBW'(rroot[RS]))
                   ? rroot[RS] + 1'b1 : rroot[RS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= rv[RS];
        r_s3  <= rs[RS];
        r_len <= (w_len == 0) ? RTW'(1) : w_len;
        r_nx  <= (NUMW'(rax[RS]) << UNIT_FRACTION_BITS) + NUMW'(w_len >> 1);
        r_ny  <= (NUMW'(ray[RS]) << UNIT_FRACTION_BITS) + NUMW'(w_len >> 1);
    end

    // Divide pipeline: both components, one quotient bit per stage.
    localparam int RW = RTW + 1;
    logic          dv  [DS+1];
    t_side         ds  [DS+1];
    logic [RTW-1:0] dl [DS+1];
    logic [NUMW-1:0] dnx[DS+1], dny[DS+1];
    logic [RW-1:0]  drx[DS+1], dry[DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) dv[0] <= 1'b0;
        else          dv[0] <= r_v3;
        ds[0]  <= r_s3;
        dl[0]  <= r_len;
        dnx[0] <= r_nx;
        dny[0] <= r_ny;
        drx[0] <= '0;
        dry[0] <= '0;
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [RW-1:0] w_px, w_py;
        assign w_px = {drx[k][RW-2:0], dnx[k][NUMW-1]};
        assign w_py = {dry[k][RW-2:0], dny[k][NUMW-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) dv[k+1] <= 1'b0;
            else          dv[k+1] <= dv[k];
            ds[k+1] <= ds[k];
            dl[k+1] <= dl[k];
            if (w_px >= RW'(dl[k])) begin
                drx[k+1] <= w_px - RW'(dl[k]);
                dnx[k+1] <= {dnx[k][NUMW-2:0], 1'b1};
            end else begin
                drx[k+1] <= w_px;
                dnx[k+1] <= {dnx[k][NUMW-2:0], 1'b0};
            end
            if (w_py >= RW'(dl[k])) begin
                dry[k+1] <= w_py - RW'(dl[k]);
                dny[k+1] <= {dny[k][NUMW-2:0], 1'b1};
            end else begin
                dry[k+1] <= w_py;
                dny[k+1] <= {dny[k][NUMW-2:0], 1'b0};
            end
        end
    end

    // Scale by speed.
    logic          r_v4;
    t_side         r_s4;
    logic [PW-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= dv[DS];
        r_s4 <= ds[DS];
        r_px <= PW'(dnx[DS] * ds[DS].speed) << COORD_FRACTION_BITS;
        r_py <= PW'(dny[DS] * ds[DS].speed) << COORD_FRACTION_BITS;
    end

    // Round, sign, add and saturate.
    function automatic logic [PW-1:0] rnd(input logic [PW-1:0] p);
        if (SHIFT_BITS == 0) return p;
        else return (p + (PW'(1) << (SHIFT_BITS - 1))) >> SHIFT_BITS;
    endfunction

    logic [PW-1:0] w_mx, w_my;
    logic signed [PW+1:0] w_sx, w_sy;
    logic sat_x, sat_y;
    logic signed [15:0] w_nx, w_ny;
    assign w_mx = rnd(r_px);
    assign w_my = rnd(r_py);

    always_comb begin
        w_sx = (PW+2)'($signed(r_s4.mover_x)) + (r_s4.neg_x ? -$signed({2'b00, w_mx})
                                                            : $signed({2'b00, w_mx}));
        w_sy = (PW+2)'($signed(r_s4.mover_y)) + (r_s4.neg_y ? -$signed({2'b00, w_my})
                                                            : $signed({2'b00, w_my}));
        sat_x = 1'b0;
        sat_y = 1'b0;
        if (w_sx > 32767) begin
            w_nx = 16'sh7fff; sat_x = 1'b1;
        end else if (w_sx < -32768) begin
            w_nx = -16'sh8000; sat_x = 1'b1;
        end else begin
            w_nx = w_sx[15:0];
        end
        if (w_sy > 32767) begin
            w_ny = 16'sh7fff; sat_y = 1'b1;
        end else if (w_sy < -32768) begin
            w_ny = -16'sh8000; sat_y = 1'b1;
        end else begin
            w_ny = w_sy[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v4;
        o_facing <= r_s4.face;
        if (r_s4.zero) begin
            o_new_x     <= r_s4.mover_x;
            o_new_y     <= r_s4.mover_y;
            o_saturated <= 1'b0;
        end else begin
            o_new_x     <= w_nx;
            o_new_y     <= w_ny;
            o_saturated <= sat_x | sat_y;
        end
    end

endmodule

@@ design/ssuv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssuv_props: port-level checks of the seek step unit vector block
// Watches the request, result and register ports over time.
// ----------------------------------------------------------------------------
module ssuv_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [1:0]  o_facing,
    input logic        o_saturated,
    input logic        pready
);
    import ssuv_pkg::*;

    localparam int LATENCY = 7 + RTW + QW;

    a_facing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_facing <= 2'(FACE_DOWN)) else $error("bad facing code");
    a_busy: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY (o_valid && !$isunknown(o_saturated)))
        else $error("result missing after a request");
endmodule

bind seek_step_unit_vector_unit ssuv_props u_ssuv_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_facing(o_facing), .o_saturated(o_saturated),
    .pready(pready)
);

@@ dv/ssuv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssuv_checker: result predictor and scoreboard for the seek step block
// Watches the request, result and register ports, computes the expected
// step for every accepted request and compares each result in order.
// ----------------------------------------------------------------------------
module ssuv_checker
    import ssuv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_mover_x,
    input  logic signed [15:0] i_mover_y,
    input  logic               i_valid,
    input  logic signed [15:0] i_new_x,
    input  logic signed [15:0] i_new_y,
    input  logic [1:0]         i_facing,
    input  logic               i_saturated,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [1:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        t_facing            face;
        logic               sat;
    } t_move;

    t_move          moves_q[$];
    logic [SPW-1:0] speed;

    function automatic longint unsigned rounded_root(longint unsigned n);
        longint unsigned rem, root, b;
        rem  = n;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        if (rem > root) root = root + 1;
        return root;
    endfunction

    function automatic longint axis_offset(longint d, longint unsigned len,
                                           logic [SPW-1:0] spd);
        longint unsigned mag, unit, prod, mv;
        mag  = (d < 0) ? -d : d;
        unit = ((mag << UNIT_FRACTION_BITS) + (len >> 1)) / len;
        prod = (unit * spd) << COORD_FRACTION_BITS;
        if (SHIFT_BITS == 0) mv = prod;
        else mv = (prod + (64'd1 << (SHIFT_BITS - 1))) >> SHIFT_BITS;
        return (d < 0) ? -longint'(mv) : longint'(mv);
    endfunction

    function automatic t_move predict_move(logic signed [15:0] tx, ty, mx, my,
                                           logic [SPW-1:0] spd);
        t_move           m;
        longint          dx, dy, px, py;
        longint unsigned ax, ay, len;
        dx = longint'(tx) - longint'(mx);
        dy = longint'(ty) - longint'(my);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > ay) m.face = (dx > 0) ? FACE_RIGHT : FACE_LEFT;
        else if (dy > 0) m.face = FACE_DOWN;
        else m.face = (dx > 0) ? FACE_RIGHT : FACE_LEFT;
        m.nx  = mx;
        m.ny  = my;
        m.sat = 1'b0;
        if (ax != 0 || ay != 0) begin
            len = rounded_root(ax * ax + ay * ay);
            px  = longint'(mx) + axis_offset(dx, len, spd);
            py  = longint'(my) + axis_offset(dy, len, spd);
            if (px > 32767) begin m.nx = 16'sh7fff; m.sat = 1'b1; end
            else if (px < -32768) begin m.nx = 16'sh8000; m.sat = 1'b1; end
            else m.nx = px[15:0];
            if (py > 32767) begin m.ny = 16'sh7fff; m.sat = 1'b1; end
            else if (py < -32768) begin m.ny = 16'sh8000; m.sat = 1'b1; end
            else m.ny = py[15:0];
        end
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_move want;
        if (!i_rst_n) begin
            speed = SPEED_RESET;
            moves_q.delete();
        end else begin
            if (i_valid) begin
                if (moves_q.size() == 0) begin
                    $display("%0t: result with none expected: x=%0d y=%0d", $time,
                             i_new_x, i_new_y);
                    o_errors = o_errors + 1;
                end else begin
                    want = moves_q.pop_front();
                    if (i_new_x !== want.nx || i_new_y !== want.ny ||
                        i_facing !== want.face || i_saturated !== want.sat) begin
                        $display("%0t: mismatch expected x=%0d y=%0d face=%0d sat=%0d",
                                 $time, want.nx, want.ny, want.face, want.sat);
                        $display("%0t:            actual x=%0d y=%0d face=%0d sat=%0d",
                                 $time, i_new_x, i_new_y, i_facing, i_saturated);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                moves_q.push_back(predict_move(i_target_x, i_target_y,
                                               i_mover_x, i_mover_y, speed));
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == 2'(ADDR_STEP_SPEED))
                speed = i_pwdata[SPW-1:0];
        end
        o_pending = moves_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        speed     = SPEED_RESET;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the seek step unit vector block
// Runs directed and random requests under several step speeds, with random
// gaps in the request stream; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import ssuv_pkg::*;

    logic               clk, rst_n, start, busy, valid, saturated;
    logic signed [15:0] target_x, target_y, mover_x, mover_y, new_x, new_y;
    logic [1:0]         facing, paddr;
    logic               psel, penable, pwrite, pready;
    logic [31:0]        pwdata, prdata;
    int                 errors, pending;

    seek_step_unit_vector_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_target_x(target_x), .i_target_y(target_y),
        .i_mover_x(mover_x), .i_mover_y(mover_y),
        .o_valid(valid), .o_new_x(new_x), .o_new_y(new_y),
        .o_facing(facing), .o_saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ssuv_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_target_x(target_x), .i_target_y(target_y),
        .i_mover_x(mover_x), .i_mover_y(mover_y),
        .i_valid(valid), .i_new_x(new_x), .i_new_y(new_y),
        .i_facing(facing), .i_saturated(saturated),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Drives one request at the falling edge, holds it until accepted, and may then idle for a random gap.
    task automatic send_request(input logic signed [15:0] tx, ty, mx, my,
                                input bit idle_ok);
        @(negedge clk);
        start    <= 1'b1;
        target_x <= tx;
        target_y <= ty;
        mover_x  <= mx;
        mover_y  <= my;
        do @(posedge clk); while (busy);
        if (idle_ok && $urandom_range(0, 7) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // Waits for every outstanding result, lets the pipeline drain, then writes the step speed.
    task automatic drain_then_set_speed(input logic [7:0] spd);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 2'(ADDR_STEP_SPEED);
        pwdata  <= {24'($urandom_range(0, 16777215)), spd};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_request(input bit idle_ok);
        logic signed [15:0] mx, my;
        mx = 16'($urandom);
        my = 16'($urandom);
        case ($urandom_range(0, 3))
            0: send_request(16'($urandom), 16'($urandom), mx, my, idle_ok);
            1: send_request(mx + 16'($signed($urandom_range(0, 64)) - 32),
                            my + 16'($signed($urandom_range(0, 64)) - 32), mx, my,
                            idle_ok);
            2: send_request(mx, my, mx, my, idle_ok);
            default: send_request(mx + 16'($signed($urandom_range(0, 4096)) - 2048),
                                  my + 16'($signed($urandom_range(0, 4096)) - 2048),
                                  mx, my, idle_ok);
        endcase
    endtask

    initial begin
        logic [7:0] speeds[5];
        int         wait_cycles;
        speeds  = '{8'd255, 8'd0, 8'd37, 8'd1, 8'd255};
        rst_n   = 1'b0;
        start   = 1'b0;
        target_x = '0; target_y = '0; mover_x = '0; mover_y = '0;
        psel    = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset speed of one.
        send_request(16'sd100, 16'sd100, 16'sd100, 16'sd100, 0);  // zero length
        send_request(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 0); // widest right
        send_request(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 0); // widest left
        send_request(16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 0); // widest down
        send_request(16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 0); // straight up
        send_request(16'sd50, 16'sd50, 16'sd0, 16'sd0, 0);        // tie going down
        send_request(16'sd50, -16'sd50, 16'sd0, 16'sd0, 0);       // tie up and right
        send_request(-16'sd50, -16'sd50, 16'sd0, 16'sd0, 0);      // tie up and left
        send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32760, 0);
        send_request(16'sd0, 16'sd1, 16'sd0, 16'sd0, 0);

        for (int p = 0; p < 5; p++) begin
            drain_then_set_speed(speeds[p]);
            // Steps toward the edges of the range, and one of zero length.
            send_request(16'sd32767, 16'sd32767, 16'sd32760, 16'sd32700, 0);
            send_request(-16'sd32768, -16'sd32768, -16'sd32760, -16'sd32700, 0);
            send_request(16'sd7, -16'sd3, 16'sd7, -16'sd3, 0);
            for (int i = 0; i < 100; i++)
                random_request(p < 4);
        end

        @(negedge clk);
        start <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 10000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (80) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
